// ===== sv/lzwd_pkg.sv =====
package lzwd_pkg;

  localparam int unsigned WIN_DEPTH = 2048;
  localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);
  localparam int unsigned FILL_W    = WIN_AW + 1;
  localparam int unsigned CNT_W     = 24;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned FLAG_W    = 16;

  localparam logic [WIN_AW-1:0] PTR_START   = WIN_AW'(2015);
  localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(WIN_DEPTH);
  localparam logic [CNT_W-1:0]  LIMIT_RESET = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0]  MIN_COPY    = LEN_W'(2);
  localparam logic [7:0]        FLAG_FILL   = 8'hFF;

  typedef struct packed {
    logic       stream_start;
    logic [7:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       run_last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;  // an input item may be accepted this cycle
    logic step;  // emit one copied byte this cycle
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // output register can load this cycle
    logic copy_go;    // accepted item starts a back-reference copy
    logic copy_last;  // the pending copy byte is the final one
  } status_t;

endpackage

// ===== sv/lzwd_ram.sv =====
module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the contents before a write in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lzwd_ctrl.sv =====
module lzwd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lzwd_pkg::status_t status_i,
  output lzwd_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_COPY_RD = 3'b010,
    ST_COPY    = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.take = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = status_i.out_free;
        if (status_i.copy_go) begin
          state_d = ST_COPY_RD;
        end
      end
      // The first read of the copy is in flight.
      ST_COPY_RD: begin
        state_d = ST_COPY;
      end
      ST_COPY: begin
        cmd_o.step = status_i.out_free;
        if (status_i.out_free && status_i.copy_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/lzwd_dp.sv =====
module lzwd_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  lzwd_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lzwd_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [lzwd_pkg::CNT_W-1:0]       cfg_data_i,
  input  lzwd_pkg::cmd_t                   cmd_i,
  output lzwd_pkg::status_t                status_o
);

  localparam int unsigned AW = lzwd_pkg::WIN_AW;

  logic [lzwd_pkg::CNT_W-1:0]  limit_q;
  logic [lzwd_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]               wp_q, wp_d;
  logic [lzwd_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [lzwd_pkg::FLAG_W-1:0] flag_q, flag_d;
  logic                        await_q, await_d;
  logic [7:0]                  held_q, held_d;
  logic                        stop_q, stop_d;
  logic [AW-1:0]               rd_addr_q, rd_addr_d;
  logic [lzwd_pkg::LEN_W-1:0]  rem_q, rem_d;
  logic                        byp_q;
  logic [7:0]                  byp_data_q;
  logic                        vld_q;
  logic                        out_valid_q;
  lzwd_pkg::out_item_t         out_q;

  logic                        fire, start;
  logic [7:0]                  b;
  logic                        e_stop, e_await;
  logic [lzwd_pkg::FLAG_W-1:0] e_flag;
  logic [7:0]                  e_held;
  logic [lzwd_pkg::CNT_W-1:0]  c_cnt;
  logic [AW-1:0]               c_wp;
  logic [lzwd_pkg::FILL_W-1:0] c_fill;
  logic [lzwd_pkg::LEN_W-1:0]  len;
  logic [lzwd_pkg::CNT_W:0]    sum;
  logic                        over, atlim;
  logic                        lit_emit, copy_go, emit;
  logic [7:0]                  wdata, rdata, cbyte;
  logic [AW-1:0]               raddr, roff;
  logic                        out_free;

  assign fire  = cmd_i.take & in_valid_i;
  assign start = in_item_i.stream_start;
  assign b     = in_item_i.code_byte;

  // A stream start resets the decoder before this item's byte is decoded.
  assign e_stop  = start ? 1'b0 : stop_q;
  assign e_await = start ? 1'b0 : await_q;
  assign e_flag  = start ? '0 : flag_q;
  assign e_held  = start ? '0 : held_q;
  assign c_cnt   = (fire && start) ? '0 : cnt_q;
  assign c_wp    = (fire && start) ? lzwd_pkg::PTR_START : wp_q;
  assign c_fill  = (fire && start) ? '0 : fill_q;

  assign len   = {1'b0, b[4:0]} + lzwd_pkg::MIN_COPY;
  assign sum   = {1'b0, c_cnt} + {{(lzwd_pkg::CNT_W + 1 - lzwd_pkg::LEN_W){1'b0}}, len};
  assign over  = sum > {1'b0, limit_q};
  assign atlim = c_cnt >= limit_q;

  assign lit_emit = fire & ~e_stop & ~e_await & ~atlim & e_flag[8] & e_flag[0];
  assign copy_go  = fire & ~e_stop & e_await & ~over;
  assign emit     = lit_emit | cmd_i.step;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // Entries not yet written in this stream read as zero: the window fills
  // in order from the start pointer, so the fill count tells which are valid.
  assign cbyte = byp_q ? byp_data_q : (vld_q ? rdata : 8'h00);
  assign wdata = lit_emit ? b : cbyte;
  assign raddr = cmd_i.step ? rd_addr_q + AW'(1) : rd_addr_q;
  assign roff  = raddr - lzwd_pkg::PTR_START;

  always_comb begin
    stop_d    = stop_q;
    await_d   = await_q;
    flag_d    = flag_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    rd_addr_d = rd_addr_q;
    rem_d     = rem_q;
    if (fire) begin
      stop_d  = e_stop;
      await_d = e_await;
      flag_d  = e_flag;
      held_d  = e_held;
      cnt_d   = c_cnt;
      wp_d    = c_wp;
      fill_d  = c_fill;
      if (!e_stop) begin
        if (e_await) begin
          await_d = 1'b0;
          if (over) begin
            stop_d = 1'b1;
          end else begin
            flag_d    = e_flag >> 1;
            rd_addr_d = {b[7:5], e_held};
            rem_d     = len;
          end
        end else if (atlim) begin
          stop_d = 1'b1;
        end else if (!e_flag[8]) begin
          flag_d = {lzwd_pkg::FLAG_FILL, b};
        end else if (e_flag[0]) begin
          flag_d = e_flag >> 1;
        end else begin
          held_d  = b;
          await_d = 1'b1;
        end
      end
    end
    if (cmd_i.step) begin
      rd_addr_d = rd_addr_q + AW'(1);
      rem_d     = rem_q - lzwd_pkg::LEN_W'(1);
    end
    if (emit) begin
      cnt_d  = c_cnt + lzwd_pkg::CNT_W'(1);
      wp_d   = c_wp + AW'(1);
      fill_d = (c_fill == lzwd_pkg::FILL_FULL) ? c_fill : c_fill + lzwd_pkg::FILL_W'(1);
    end
  end

  lzwd_ram #(
    .WIDTH(8),
    .DEPTH(lzwd_pkg::WIN_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (emit),
    .waddr_i(c_wp),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= lzwd_pkg::LIMIT_RESET;
      cnt_q       <= '0;
      wp_q        <= lzwd_pkg::PTR_START;
      fill_q      <= '0;
      flag_q      <= '0;
      await_q     <= 1'b0;
      held_q      <= '0;
      stop_q      <= 1'b0;
      rem_q       <= '0;
      byp_q       <= 1'b0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      cnt_q   <= cnt_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      flag_q  <= flag_d;
      await_q <= await_d;
      held_q  <= held_d;
      stop_q  <= stop_d;
      rem_q   <= rem_d;
      // A read that hits the address written in the same cycle gets the new byte.
      byp_q   <= emit && (c_wp == raddr);
      vld_q   <= {1'b0, roff} < fill_q;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    byp_data_q <= wdata;
    if (emit) begin
      out_q.plain_byte <= wdata;
      out_q.run_last   <= lit_emit | (rem_q == lzwd_pkg::LEN_W'(1));
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_q;
  assign status_o.out_free   = out_free;
  assign status_o.copy_go    = copy_go;
  assign status_o.copy_last  = rem_q == lzwd_pkg::LEN_W'(1);

endmodule

// ===== sv/lzss_window_decoder_top.sv =====
// Channel  Direction  Payload               Handshake
// in       input      lzwd_pkg::in_item_t   in_valid_i / in_stall_o
// out      output     lzwd_pkg::out_item_t  out_valid_o / out_stall_i
// cfg      input      output_limit, 24 bit  cfg_we_i, no wait
//
// Flag bytes, reference first bytes and literals are each accepted as a single
// input item; a literal's byte is in the output register on the next cycle.
// A reference of L+2 bytes is accepted, then its first history read is made
// in ST_COPY_RD, then bytes come one per cycle from the single history read port.
// Output stalls hold the copy in place; input is stalled while a copy runs or
// the output register is full and stalled. Reset needs no clearing pass.

module lzss_window_decoder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lzwd_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lzwd_pkg::out_item_t        out_item_o,
  input  logic                       cfg_we_i,
  input  logic [lzwd_pkg::CNT_W-1:0] cfg_data_i
);

  lzwd_pkg::cmd_t    cmd;
  lzwd_pkg::status_t status;

  lzwd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .cmd_o   (cmd)
  );

  lzwd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status)
  );

  assign in_stall_o = ~cmd.take;

  a_take_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.take && cmd.step)) else $error("input taken during a copy step");

  a_prime_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.copy_go |=> !cmd.take && !cmd.step)
    else $error("copy did not wait for its first history read");

  a_copy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step && status.copy_last |=> !cmd.step)
    else $error("copy ran past its last byte");

  a_step_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |=> out_valid_o) else $error("copy step produced no item");

endmodule
